FILE: sv/slab_slot_bitmap_allocator_defines.svh
// assertion macros for the slab slot bitmap allocator
`ifndef SLAB_SLOT_BITMAP_ALLOCATOR_DEFINES_SVH
`define SLAB_SLOT_BITMAP_ALLOCATOR_DEFINES_SVH

// same-cycle implication, checked out of reset
`define SSBA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define SSBA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/ssba_pkg.sv
// shared types, constants and helpers of the slab slot bitmap allocator
`timescale 1ns / 1ps
`default_nettype none

package ssba_pkg;

  localparam int MAX_SLOTS  = 256;
  localparam int WORD_BITS  = 32;
  localparam int WORD_COUNT = (MAX_SLOTS + WORD_BITS - 1) / WORD_BITS;
  localparam int WORD_IDX_W = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
  localparam int BIT_IDX_W  = $clog2(WORD_BITS);
  localparam int SLOT_W     = 8;
  localparam int COUNT_W    = 9;
  localparam int CMD_W      = 2;
  localparam int STATUS_W   = 2;
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  localparam logic [COUNT_W-1:0] SLOT_COUNT_RESET = COUNT_W'(256);
  localparam logic [COUNT_W-1:0] MAX_SLOTS_C      = COUNT_W'(MAX_SLOTS);

  // register index taken from the word address
  typedef enum logic {
    REG_SLOT_COUNT = 1'b0
  } reg_idx_e;

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC = 2'd0,
    CMD_FREE  = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_MOD
  } state_e;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [SLOT_W-1:0] slot_index;
  } in_t;

  typedef struct packed {
    logic [SLOT_W-1:0]   slot;
    logic [STATUS_W-1:0] status;
  } out_t;

  // requests from the controller to the bitmap store
  typedef struct packed {
    logic                  rd_en;
    logic [WORD_IDX_W-1:0] rd_addr;
    logic                  wr_en;
    logic [WORD_IDX_W-1:0] wr_addr;
    logic [WORD_BITS-1:0]  wr_data;
    logic                  clr;
  } store_req_t;

  typedef struct packed {
    logic                 any;
    logic [BIT_IDX_W-1:0] pos;
  } ffz_t;

  // lowest zero bit of a bitmap word
  function automatic ffz_t find_first_zero(input logic [WORD_BITS-1:0] word);
    ffz_t r;
    r.any = 1'b0;
    r.pos = '0;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (!word[b]) begin
        r.any = 1'b1;
        r.pos = BIT_IDX_W'(b);
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: sv/ssba_store.sv
// bitmap word memory with per-word valid and full flags
`timescale 1ns / 1ps
`default_nettype none

module ssba_store (
  input  wire logic                                     clk_i,
  input  wire logic                                     rst_ni,
  input  wire ssba_pkg::store_req_t                     req_i,
  output logic [ssba_pkg::WORD_BITS-1:0]                rd_data_o,
  output logic [ssba_pkg::WORD_COUNT-1:0]               full_o
);
  import ssba_pkg::*;

  logic [WORD_BITS-1:0]  mem_q [WORD_COUNT];
  logic [WORD_BITS-1:0]  rd_data_q;
  logic                  rd_vld_q;
  logic [WORD_COUNT-1:0] word_vld_q;
  logic [WORD_COUNT-1:0] full_q;

  // word storage, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rd_data_q <= mem_q[req_i.rd_addr];
    end
  end

  // valid and full flags, cleared at once by reset or the clear command
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_vld_q <= '0;
      full_q     <= '0;
      rd_vld_q   <= 1'b0;
    end else begin
      if (req_i.rd_en) begin
        rd_vld_q <= word_vld_q[req_i.rd_addr];
      end
      if (req_i.clr) begin
        word_vld_q <= '0;
        full_q     <= '0;
      end else if (req_i.wr_en) begin
        word_vld_q[req_i.wr_addr] <= 1'b1;
        full_q[req_i.wr_addr]     <= &req_i.wr_data;
      end
    end
  end

  // a word never written reads as all free
  assign rd_data_o = rd_vld_q ? rd_data_q : '0;
  assign full_o    = full_q;

endmodule

`default_nettype wire

FILE: sv/slab_slot_bitmap_allocator.sv
// Slab slot bitmap allocator: one result per command, state held in a word memory.
// A command passes a read step, then a modify/write step, and its result is registered at the output.
// A new command is taken only after the previous one has finished its read-modify-write of one memory word.
// A full-word summary picks the word to scan, so allocate reads only one word.
// Reset: per-word valid flags mark the bitmap empty at once; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
`include "slab_slot_bitmap_allocator_defines.svh"

module slab_slot_bitmap_allocator (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire ssba_pkg::in_t                     in_data_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output ssba_pkg::out_t                         out_data_o,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [ssba_pkg::APB_ADDR_W-1:0]   paddr,
  input  wire logic [ssba_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [ssba_pkg::APB_DATA_W-1:0]        prdata,
  output logic                                   pready
);
  import ssba_pkg::*;

  state_e                state_q, state_d;
  logic [CMD_W-1:0]      cmd_q;
  logic [SLOT_W-1:0]     idx_q;
  logic [WORD_IDX_W-1:0] word_q;
  logic                  found_q;
  logic                  out_valid_q;
  out_t                  out_data_q;
  out_t                  res;
  logic [COUNT_W-1:0]    slot_count_q;
  logic [COUNT_W-1:0]    eff_count;

  store_req_t            store_req;
  logic [WORD_BITS-1:0]  rd_data;
  logic [WORD_COUNT-1:0] word_full;

  logic [WORD_COUNT-1:0] cand;
  logic [WORD_IDX_W-1:0] sel_word;
  logic                  sel_found;
  ffz_t                  ffz;
  logic [SLOT_W-1:0]     alloc_slot;
  logic                  alloc_ok;
  logic                  free_ok;
  logic [BIT_IDX_W-1:0]  bit_pos;
  logic [WORD_BITS-1:0]  bit_mask;
  logic                  in_xfer;
  logic                  done;
  logic                  cfg_wr;

  ssba_store u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (store_req),
    .rd_data_o (rd_data),
    .full_o    (word_full)
  );

  // configuration register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_SLOT_COUNT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_count_q <= SLOT_COUNT_RESET;
    end else if (cfg_wr) begin
      slot_count_q <= pwdata[COUNT_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_SLOT_COUNT) ? APB_DATA_W'(slot_count_q) : '0;

  // usable count, clamped to the slab size
  assign eff_count = (slot_count_q > MAX_SLOTS_C) ? MAX_SLOTS_C : slot_count_q;

  // lowest word that starts below the count and is not full
  always_comb begin
    sel_word  = '0;
    sel_found = 1'b0;
    for (int w = 0; w < WORD_COUNT; w++) begin
      cand[w] = (COUNT_W'(w * WORD_BITS) < eff_count) && !word_full[w];
    end
    for (int w = WORD_COUNT - 1; w >= 0; w--) begin
      if (cand[w]) begin
        sel_word  = WORD_IDX_W'(w);
        sel_found = 1'b1;
      end
    end
  end

  // modify stage: bit search and range checks on the word read back
  assign ffz        = find_first_zero(rd_data);
  assign alloc_slot = SLOT_W'({word_q, ffz.pos});
  assign alloc_ok   = found_q && ffz.any && (COUNT_W'(alloc_slot) < eff_count);
  assign free_ok    = COUNT_W'(idx_q) < eff_count;
  assign bit_pos    = (cmd_q == CMD_ALLOC) ? ffz.pos : idx_q[BIT_IDX_W-1:0];
  assign bit_mask   = WORD_BITS'(1) << bit_pos;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign done       = (state_q == S_MOD) && (!out_valid_q || out_ready_i);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_xfer) state_d = S_READ;
      end
      S_READ: begin
        state_d = S_MOD;
      end
      S_MOD: begin
        if (done) state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // store requests and result
  always_comb begin
    store_req         = '0;
    store_req.wr_addr = word_q;
    res.slot          = '0;
    res.status        = ST_OK;
    unique case (state_q)
      S_READ: begin
        store_req.rd_en   = 1'b1;
        store_req.rd_addr = (cmd_q == CMD_ALLOC) ? sel_word
                                                 : idx_q[SLOT_W-1 -: WORD_IDX_W];
      end
      S_MOD: begin
        case (cmd_q)
          CMD_ALLOC: begin
            if (alloc_ok) begin
              res.slot          = alloc_slot;
              store_req.wr_en   = done;
              store_req.wr_data = rd_data | bit_mask;
            end else begin
              res.status = ST_FULL;
            end
          end
          CMD_FREE: begin
            if (free_ok) begin
              store_req.wr_en   = done;
              store_req.wr_data = rd_data & ~bit_mask;
            end else begin
              res.status = ST_RANGE;
            end
          end
          CMD_CLEAR: begin
            store_req.clr = done;
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  // command and scan registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      cmd_q <= in_data_i.command;
      idx_q <= in_data_i.slot_index;
    end
    if (state_q == S_READ) begin
      word_q  <= (cmd_q == CMD_ALLOC) ? sel_word : idx_q[SLOT_W-1 -: WORD_IDX_W];
      found_q <= sel_found;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (done) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done) begin
      out_data_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // checks
  `SSBA_ASSERT_NOW(a_alloc_in_range,
    out_valid_q && (out_data_q.status == ST_OK) && (out_data_q.slot != '0),
    COUNT_W'(out_data_q.slot) < eff_count, "allocated slot at or above slot count")
  `SSBA_ASSERT_NOW(a_write_in_mod,
    store_req.wr_en || store_req.clr, state_q == S_MOD, "store written outside modify step")
  `SSBA_ASSERT_NOW(a_read_in_read,
    store_req.rd_en, state_q == S_READ, "store read outside read step")
  `SSBA_ASSERT_NEXT(a_result_follows,
    done, out_valid_q && (state_q == S_IDLE), "finished command did not post a result")

endmodule

`default_nettype wire
